@@ hw/rtl/bmrs_pkg.sv @@
package bmrs_pkg;

    // Default geometry of the map.
    localparam int MAP_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 64;

    // Field widths of the ports.
    localparam int KIND_W   = 2;
    localparam int BOUND_W  = 16;
    localparam int CFG_W    = 11;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 10;

    // Reset value of the bit count register.
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LO_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HI_RANGE = 2'd2;

endpackage

@@ hw/rtl/bitmap_range_set_clear_find.sv @@
// Allocation bitmap of MAP_BITS bits held in a RAM of WORD_BITS-bit words and
// cleared by reset. Each input word carries an operation (set range, clear range
// or query) and two bounds of a half-open bit range; reversed bounds are swapped.
// A bound above min(bits_in_use, MAP_BITS) is rejected with a status code and the
// map stays unchanged. A query reports whether any bit in the range is set and the
// distance of the first set bit from the lower bound. After reset the block sweeps
// zeros through the RAM, one word per cycle, and in_stall stays high until the
// sweep has passed the last word. Each word then passes through the idle state in
// which it is taken, the bound check, one RAM read-modify-write step for every
// map word from word zero up to the word that holds the upper bound (a query
// stops at the first word with a hit), a find step when a query hits, and a done
// step that hands the result to the output register; the single RAM port pair
// is walked one word at a time. A rejected word or an empty range goes from the
// bound check straight to the done step. The hand-off waits while the output
// register still holds a stalled result. The next input word is taken while a
// result still waits in the output register.
module bitmap_range_set_clear_find
    import bmrs_pkg::*;
#(
    parameter int MAP_BITS  = MAP_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [BOUND_W-1:0]  range_start,
    input  logic [BOUND_W-1:0]  range_stop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                any_set,
    output logic [OFF_W-1:0]    first_offset
);

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int PW        = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int IW        = $clog2(WORD_BITS);
    localparam int CW        = BOUND_W + 1;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_RUN   = 6'b001000,
        ST_FIND  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Control registers.
    state_t           state_reg, state_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic             out_valid_reg, out_valid_next;
    logic [CFG_W-1:0] bits_in_use_reg;

    // Payload registers.
    logic [KIND_W-1:0]    kind_reg;
    logic [BOUND_W-1:0]   start_reg;
    logic [BOUND_W-1:0]   stop_reg;
    logic [PW-1:0]        lo_reg, lo_next;
    logic [PW-1:0]        hi_reg, hi_next;
    logic [PW-1:0]        base_reg, base_next;
    logic [WORD_BITS-1:0] hit_word_reg, hit_word_next;
    logic [PW-1:0]        hit_base_reg, hit_base_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 res_any_reg, res_any_next;
    logic [OFF_W-1:0]     res_off_reg, res_off_next;
    logic [STATUS_W-1:0]  status_reg;
    logic                 any_set_reg;
    logic [OFF_W-1:0]     first_offset_reg;
    logic                 load_out;

    // RAM ports.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Word unit results.
    logic [WORD_BITS-1:0] op_wdata;
    logic [WORD_BITS-1:0] op_hits;
    logic                 op_hit;

    // Bound check.
    logic [BOUND_W-1:0] lo_sw, hi_sw;
    logic [CW-1:0]      lo_chk, hi_chk, limit;

    // First set bit of a hit word.
    logic [WORD_BITS-1:0] hit_iso;
    logic [IW-1:0]        hit_idx;

    logic                 in_accept;
    logic                 last_word;
    logic [PW:0]          base_end;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign last_word = (cur_reg == AW'(NUM_WORDS - 1));
    assign base_end  = (PW+1)'(base_reg) + (PW+1)'(WORD_BITS);

    bmrs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmrs_word_op #(
        .WORD_BITS (WORD_BITS),
        .PW        (PW)
    ) u_word_op (
        .kind  (kind_reg),
        .lo    (lo_reg),
        .hi    (hi_reg),
        .base  (base_reg),
        .rdata (ram_rdata),
        .wdata (op_wdata),
        .hits  (op_hits),
        .hit   (op_hit)
    );

    // Order the bounds and compare them with the effective bit count, which is
    // the register value capped at the size of the map.
    always_comb
    begin
        if (stop_reg < start_reg)
        begin
            lo_sw = stop_reg;
            hi_sw = start_reg;
        end
        else
        begin
            lo_sw = start_reg;
            hi_sw = stop_reg;
        end
        lo_chk = CW'(lo_sw);
        hi_chk = CW'(hi_sw);
        if (CW'(bits_in_use_reg) < CW'(MAP_BITS))
        begin
            limit = CW'(bits_in_use_reg);
        end
        else
        begin
            limit = CW'(MAP_BITS);
        end
    end

    // Isolate the lowest set bit of the hit word and encode its position.
    always_comb
    begin
        hit_iso = hit_word_reg & (~hit_word_reg + 1'b1);
        hit_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (hit_iso[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
    end

    // Sequencer. The RAM read for a word is issued in the cycle before its data is
    // used, so in the run state the data of word cur_reg is present while the read
    // of the next word goes out and the modified word is written back.
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        base_next       = base_reg;
        hit_word_next   = hit_word_reg;
        hit_base_next   = hit_base_reg;
        res_status_next = res_status_reg;
        res_any_next    = res_any_reg;
        res_off_next    = res_off_reg;
        load_out        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = op_wdata;
        ram_re          = 1'b0;
        ram_raddr       = cur_reg;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (last_word)
                begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cur_next        = '0;
                base_next       = '0;
                lo_next         = PW'(lo_chk);
                hi_next         = PW'(hi_chk);
                res_status_next = STATUS_OK;
                res_any_next    = 1'b0;
                res_off_next    = '0;
                if (lo_chk > limit)
                begin
                    res_status_next = STATUS_LO_RANGE;
                    state_next      = ST_DONE;
                end
                else if (hi_chk > limit)
                begin
                    res_status_next = STATUS_HI_RANGE;
                    state_next      = ST_DONE;
                end
                else if ((kind_reg == KIND_SET || kind_reg == KIND_CLEAR
                          || kind_reg == KIND_QUERY) && (lo_chk != hi_chk))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN:
            begin
                ram_we = (kind_reg != KIND_QUERY);
                if (kind_reg == KIND_QUERY && op_hit)
                begin
                    hit_word_next = op_hits;
                    hit_base_next = base_reg;
                    state_next    = ST_FIND;
                end
                else if (last_word || (base_end >= (PW+1)'(hi_reg)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_reg + 1'b1;
                    cur_next   = cur_reg + 1'b1;
                    base_next  = base_reg + PW'(WORD_BITS);
                end
            end
            ST_FIND:
            begin
                res_any_next = 1'b1;
                res_off_next = OFF_W'(hit_base_reg + PW'(hit_idx) - lo_reg);
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                cur_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            cur_reg         <= '0;
            out_valid_reg   <= 1'b0;
            bits_in_use_reg <= CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                bits_in_use_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg  <= kind;
            start_reg <= range_start;
            stop_reg  <= range_stop;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        base_reg       <= base_next;
        hit_word_reg   <= hit_word_next;
        hit_base_reg   <= hit_base_next;
        res_status_reg <= res_status_next;
        res_any_reg    <= res_any_next;
        res_off_reg    <= res_off_next;
        if (load_out)
        begin
            status_reg       <= res_status_reg;
            any_set_reg      <= res_any_reg;
            first_offset_reg <= res_off_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign any_set      = any_set_reg;
    assign first_offset = first_offset_reg;

    // The map is written only by the clearing sweep and by set or clear words.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_INIT || state_reg == ST_RUN))
        else $error("map written outside the sweep or a set/clear pass");

    // A query never changes the map.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && kind_reg == KIND_QUERY) |-> !ram_we)
        else $error("query wrote the map");

    // An accepted word always goes to the bound check next.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_CHECK))
        else $error("accepted word did not reach the bound check");

    // A hit is only reported for a request that passed the bound check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && any_set) |-> (status == STATUS_OK))
        else $error("hit reported with an error status");

    // A nonzero offset comes only with a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_offset != '0) |-> any_set)
        else $error("offset reported without a hit");

endmodule

@@ hw/rtl/bmrs_ram.sv @@
module bmrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bmrs_word_op.sv @@
module bmrs_word_op
    import bmrs_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int PW        = 11
) (
    input  logic [KIND_W-1:0]    kind,
    input  logic [PW-1:0]        lo,
    input  logic [PW-1:0]        hi,
    input  logic [PW-1:0]        base,
    input  logic [WORD_BITS-1:0] rdata,
    output logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] hits,
    output logic                 hit
);

    localparam int OW = $clog2(WORD_BITS + 1);

    logic [PW-1:0]        lo_diff;
    logic [PW-1:0]        hi_diff;
    logic [OW-1:0]        lo_off;
    logic [OW-1:0]        hi_off;
    logic [WORD_BITS-1:0] mask;

    // Clip both bounds of the range to this word.
    always_comb
    begin
        lo_diff = lo - base;
        hi_diff = hi - base;
        if (lo <= base)
        begin
            lo_off = '0;
        end
        else if (lo_diff >= PW'(WORD_BITS))
        begin
            lo_off = OW'(WORD_BITS);
        end
        else
        begin
            lo_off = OW'(lo_diff);
        end
        if (hi <= base)
        begin
            hi_off = '0;
        end
        else if (hi_diff >= PW'(WORD_BITS))
        begin
            hi_off = OW'(WORD_BITS);
        end
        else
        begin
            hi_off = OW'(hi_diff);
        end
    end

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[i] = (OW'(i) >= lo_off) && (OW'(i) < hi_off);
        end
    end

    always_comb
    begin
        case (kind)
            KIND_SET:   wdata = rdata | mask;
            KIND_CLEAR: wdata = rdata & ~mask;
            default:    wdata = rdata;
        endcase
    end

    assign hits = rdata & mask;
    assign hit  = |hits;

endmodule

@@ tb/bitmap_range_set_clear_find_tb.sv @@
module bitmap_range_set_clear_find_tb
    import bmrs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The testbench runs the block with its default geometry.
    localparam int MAP_BITS  = MAP_BITS_DEF;
    localparam int WORD_BITS = WORD_BITS_DEF;

    // The operation code that the package leaves unnamed. The block must still
    // check the bounds for it, but it must not touch the map.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // The largest value the 11-bit bit count register can hold.
    localparam int CFG_MAX = (1 << CFG_W) - 1;

    // The run is stopped here no matter what. The slowest correct run is about
    // 2000 words, plus sender gaps and receiver stalls, which stays well below
    // this limit.
    localparam int CYCLE_LIMIT = 600000;

    // Cycles to watch the output after the last expected result. This covers
    // the longest walk over the map, so a late, spurious result gets caught.
    localparam int DRAIN_CYCLES = 40;

    // Only the first mismatches are printed, but every one is counted.
    localparam int PRINT_LIMIT = 50;

    // One result word as the block hands it out.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                any_set;
        logic [OFF_W-1:0]    first_offset;
    } lookup_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [KIND_W-1:0]   kind;
    logic [BOUND_W-1:0]  range_start;
    logic [BOUND_W-1:0]  range_stop;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic                any_set;
    logic [OFF_W-1:0]    first_offset;

    // Shadow copy of the allocation map and of the bit count register. They
    // are updated at the moment the block accepts a word or a register write.
    logic [MAP_BITS-1:0] shadow_map;
    int                  used_bits_shadow;

    // Results the block still owes, oldest first.
    lookup_result_t      pending_results[$];

    int                  mismatch_count;
    int                  cycle_count;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int                  send_idle_pct;
    int                  recv_stall_pct;

    bitmap_range_set_clear_find #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .range_start  (range_start),
        .range_stop   (range_stop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .any_set      (any_set),
        .first_offset (first_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The watchdog. A run that hangs on a handshake ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver decides on its stall at every falling edge, so the block
    // sees a stable value at the next rising edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // The effective bit count: a register value above the map size acts as
    // the map size.
    function automatic int effective_limit();
        return (used_bits_shadow < MAP_BITS) ? used_bits_shadow : MAP_BITS;
    endfunction

    // Applies one request to the shadow map and returns the result the block
    // must give for it. Reversed bounds are swapped before anything else, the
    // lower bound is checked first, and a rejected request leaves the map as
    // it was. The query fields stay zero for everything but a query that
    // finds a set bit, and the unused operation code only reports a status.
    function automatic lookup_result_t apply_request(input logic [KIND_W-1:0] op,
                                                     input logic [BOUND_W-1:0] bound_a,
                                                     input logic [BOUND_W-1:0] bound_b);
        lookup_result_t res;
        int             lo;
        int             hi;
        int             limit;
        int             i;

        res   = '0;
        lo    = bound_a;
        hi    = bound_b;
        limit = effective_limit();
        if (hi < lo)
        begin
            i  = lo;
            lo = hi;
            hi = i;
        end
        if (lo > limit)
        begin
            res.status = STATUS_LO_RANGE;
        end
        else if (hi > limit)
        begin
            res.status = STATUS_HI_RANGE;
        end
        else
        begin
            res.status = STATUS_OK;
            if (op == KIND_SET || op == KIND_CLEAR)
            begin
                for (i = lo; i < hi; i++)
                    shadow_map[i] = (op == KIND_SET);
            end
            else if (op == KIND_QUERY)
            begin
                for (i = lo; i < hi && !res.any_set; i++)
                begin
                    if (shadow_map[i])
                    begin
                        res.any_set      = 1'b1;
                        res.first_offset = OFF_W'(i - lo);
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                     what, cycle_count, got, want);
    endtask

    // Every accepted result word is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        lookup_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing expected", status, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (any_set !== want.any_set)
                    report_mismatch("any_set", any_set, want.any_set);
                if (first_offset !== want.first_offset)
                    report_mismatch("first_offset", first_offset, want.first_offset);
            end
        end
    end

    // Sends one request word. It is entered and left at a falling edge. The
    // valid stays high when the task returns, so back-to-back words keep it
    // high; a gap lowers it first. The expectation is queued at the edge that
    // accepts the word.
    task automatic send_word(input logic [KIND_W-1:0]  op,
                             input logic [BOUND_W-1:0] bound_a,
                             input logic [BOUND_W-1:0] bound_b);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        kind        <= op;
        range_start <= bound_a;
        range_stop  <= bound_b;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_request(op, bound_a, bound_b));
        @(negedge clk);
    endtask

    // Lowers the valid and waits until the block has handed out every result
    // it owes. Since every word causes exactly one result, the block is idle
    // once the queue is empty.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // Writes the bit count register while the block is idle.
    task automatic write_bit_count(input int value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(negedge clk);
        cfg_wr_en        <= 1'b0;
        used_bits_shadow = value & CFG_MAX;
    endtask

    // One random request. Most are well-formed ranges inside the bit count,
    // mostly short so that the map gets a varied pattern; the rest poke at the
    // upper bound check or are plain noise over the whole 16-bit field.
    task automatic send_random_word();
        int                limit;
        int                roll;
        int                lo;
        int                hi;
        int                len;
        logic [KIND_W-1:0] op;

        limit = effective_limit();
        roll  = $urandom_range(0, 99);
        if (roll < 30)
            op = KIND_SET;
        else if (roll < 58)
            op = KIND_CLEAR;
        else if (roll < 95)
            op = KIND_QUERY;
        else
            op = KIND_UNUSED;

        roll = $urandom_range(0, 99);
        if (roll < 82)
        begin
            lo = $urandom_range(0, limit);
            case ($urandom_range(0, 3))
                0, 1:    len = $urandom_range(0, 24);
                2:       len = $urandom_range(0, 200);
                default: len = limit;
            endcase
            hi = (lo + len > limit) ? limit : lo + len;
        end
        else if (roll < 92)
        begin
            lo = $urandom_range(0, limit);
            hi = limit + $urandom_range(1, 3);
        end
        else
        begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
        end

        // About a third of the words arrive with reversed bounds.
        if ($urandom_range(0, 2) == 0)
            send_word(op, BOUND_W'(hi), BOUND_W'(lo));
        else
            send_word(op, BOUND_W'(lo), BOUND_W'(hi));
    endtask

    // Corners at the reset bit count: an empty map after reset, whole-map
    // ranges, the last bit, word boundaries, reversed and equal bounds, bounds
    // beyond the bit count (one, the other and both), the widest field values
    // and the unused operation code.
    task automatic test_directed_corners();
        send_word(KIND_QUERY, 16'd0, 16'(MAP_BITS));
        send_word(KIND_SET, 16'd0, 16'(MAP_BITS));
        send_word(KIND_QUERY, 16'd0, 16'(MAP_BITS));
        send_word(KIND_CLEAR, 16'(MAP_BITS), 16'd0);
        send_word(KIND_QUERY, 16'(MAP_BITS), 16'd0);
        send_word(KIND_SET, 16'(MAP_BITS - 1), 16'(MAP_BITS));
        send_word(KIND_QUERY, 16'd0, 16'(MAP_BITS));
        send_word(KIND_QUERY, 16'(MAP_BITS), 16'(MAP_BITS - 24));
        send_word(KIND_SET, 16'd5, 16'd5);
        send_word(KIND_QUERY, 16'd0, 16'd64);
        send_word(KIND_QUERY, 16'(MAP_BITS - 1), 16'(MAP_BITS - 1));
        send_word(KIND_SET, 16'd63, 16'd65);
        send_word(KIND_QUERY, 16'd0, 16'd64);
        send_word(KIND_QUERY, 16'd64, 16'd128);
        send_word(KIND_CLEAR, 16'd64, 16'd65);
        send_word(KIND_QUERY, 16'd60, 16'd70);
        send_word(KIND_SET, 16'(MAP_BITS + 1), 16'd2000);
        send_word(KIND_CLEAR, 16'd0, 16'(MAP_BITS + 1));
        send_word(KIND_QUERY, 16'hFFFF, 16'd0);
        send_word(KIND_SET, 16'hFFFF, 16'hFFFF);
        send_word(KIND_UNUSED, 16'd0, 16'(MAP_BITS));
        send_word(KIND_UNUSED, 16'd0, 16'd2000);
        send_word(KIND_UNUSED, 16'd3000, 16'd2000);
        send_word(KIND_QUERY, 16'd0, 16'(MAP_BITS));
    endtask

    // Walks the bit count register through its extremes and a few values
    // around word boundaries, including values above the map size, and
    // checks the ranges right at and just past the limit for each.
    task automatic test_bit_count_limits();
        int settings[$];
        int limit;

        settings = '{0, 1, 63, 64, 65, 1023, 1024, 1025, 1500, CFG_MAX};
        settings.push_back($urandom_range(2, 1022));
        foreach (settings[k])
        begin
            write_bit_count(settings[k]);
            limit = effective_limit();
            send_word(KIND_SET, 16'd0, 16'(limit));
            send_word(KIND_QUERY, 16'(limit), 16'd0);
            send_word(KIND_SET, 16'(limit), 16'(limit + 1));
            send_word(KIND_QUERY, 16'(limit + 1), 16'(limit + 1));
            send_word(KIND_CLEAR, 16'(limit / 2), 16'(limit));
            send_word(KIND_QUERY, 16'd0, 16'(limit));
            send_word(KIND_QUERY, 16'(limit / 2), 16'(limit));
            repeat (6)
                send_random_word();
            send_word(KIND_CLEAR, 16'd0, 16'(limit));
        end
    endtask

    // Random traffic under one idling setting. The bit count changes every 60
    // words, to the full map half the time, else to any value the register can
    // hold or to one near the map size. Each change drains the block first, and
    // the task ends by holding the sender until every expected result has come.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int sent;
        int pick;

        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                write_bit_count(MAP_BITS);
            else if (pick < 8)
                write_bit_count($urandom_range(0, CFG_MAX));
            else
                write_bit_count($urandom_range(MAP_BITS - 24, MAP_BITS));
            repeat (60)
            begin
                send_random_word();
                sent++;
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_valid         = 1'b0;
        kind             = KIND_SET;
        range_start      = '0;
        range_stop       = '0;
        out_stall        = 1'b0;
        shadow_map       = '0;
        used_bits_shadow = CFG_RESET;
        mismatch_count   = 0;
        cycle_count      = 0;
        send_idle_pct    = 12;
        recv_stall_pct   = 66;

        // Reset is held from time zero and released at a falling edge. The
        // block then clears its map and holds in_stall high meanwhile, which
        // the first word simply waits out.
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_bit_count_limits();
        test_random_traffic(12, 66, 600);
        test_random_traffic(66, 12, 600);
        test_random_traffic(0, 0, 600);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
